// File: rtl/ddws_pkg.sv
// Shared constants, register codes and pipeline types for the
// differential-drive wheel speed block. No dependencies.
`default_nettype none

package ddws_pkg;

  localparam int RPM_WIDTH = 16;
  localparam longint RPM_MAX = (longint'(1) << (RPM_WIDTH - 1)) - 1;

  localparam int IN_W    = 16;
  localparam int TRACK_W = 12;
  localparam int FAC_W   = 24;
  localparam int LIM_W   = 15;
  localparam int CFG_W   = 24;
  localparam int CFG_IDX_W = 3;

  localparam int SUM_W  = 29;
  localparam int N_W    = SUM_W + FAC_W;
  localparam int B_LSB  = 20;
  localparam int B_W    = 32;
  localparam int QW     = 25;
  localparam int PW     = QW + LIM_W;

  // floor(x/125) = (x * RECIP) >> RECIP_SHIFT for x < 2^32
  localparam int RECIP_SHIFT = 40;
  localparam int RECIP_SPLIT = 17;
  localparam logic [33:0] RECIP = 34'd8796093023;
  localparam logic [RECIP_SPLIT-1:0] RECIP_LO = RECIP[RECIP_SPLIT-1:0];
  localparam logic [RECIP_SPLIT-1:0] RECIP_HI = RECIP[33:RECIP_SPLIT];
  localparam int PP_W  = B_W + RECIP_SPLIT;
  localparam int ACC_W = B_W + 34;

  localparam int DIV_STEPS = LIM_W;
  localparam int ST_DIV    = 6;
  localparam int NS        = ST_DIV + DIV_STEPS + 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TRACK = 3'd0,
    CFG_FAC   = 3'd1,
    CFG_LIMIT = 3'd2,
    CFG_LINV  = 3'd3,
    CFG_RINV  = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic                      scale;
    logic                      limited;
    logic [1:0]                sign;
    logic [QW-1:0]             m;
    logic [1:0][PW-1:0]        rem;
    logic [1:0][LIM_W-1:0]     quo;
  } div_t;

endpackage

`default_nettype wire

// File: rtl/ddws_if.sv
// Valid/ready channel interfaces for chassis commands and wheel results.
// Depends on ddws_pkg.
`default_nettype none

interface ddws_cmd_if;
  logic                                valid;
  logic                                ready;
  logic signed [ddws_pkg::IN_W-1:0]    linear_mmps;
  logic signed [ddws_pkg::IN_W-1:0]    angular_mradps;

  modport source (output valid, output linear_mmps, output angular_mradps, input ready);
  modport sink   (input valid, input linear_mmps, input angular_mradps, output ready);
endinterface

interface ddws_wheel_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [ddws_pkg::RPM_WIDTH-1:0] left_speed;
  logic signed [ddws_pkg::RPM_WIDTH-1:0] right_speed;
  logic                                  was_limited;

  modport source (output valid, output left_speed, output right_speed, output was_limited,
                  input ready);
  modport sink   (input valid, input left_speed, input right_speed, input was_limited,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/diff_drive_wheel_speed.sv
// Differential-drive inverse kinematics with proportional speed limiting.
// Depends on ddws_pkg and the channel interfaces in ddws_if.sv.
//
// One chassis command in, one pair of wheel rpm out, one transfer per clock
// when the output side keeps up. Six stages form the exact rim-speed product
// and divide it by 2000*65536 through a split reciprocal multiply, one stage
// makes the limit decision and sets up the divider, then a 15-stage restoring
// divider (one quotient bit per stage, both wheels side by side) applies
// limit/max scaling, and a final register applies polarity. Every stage holds
// its item while the stage after it is full, so a stalled output loses nothing
// and the pipe keeps filling.
// Write configuration only while no command is in flight.
`default_nettype none

module diff_drive_wheel_speed (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [ddws_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [ddws_pkg::CFG_W-1:0]         cfg_data_i,
  ddws_cmd_if.sink                                cmd_i,
  ddws_wheel_if.source                            wheel_o
);

  localparam int NS = ddws_pkg::NS;
  localparam int SD = ddws_pkg::ST_DIV;
  localparam int DS = ddws_pkg::DIV_STEPS;

  logic [ddws_pkg::TRACK_W-1:0] track_q;
  logic [ddws_pkg::FAC_W-1:0]   fac_q;
  logic [ddws_pkg::LIM_W-1:0]   spd_q;
  logic                         linv_q;
  logic                         rinv_q;
  logic [ddws_pkg::LIM_W-1:0]   lim_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      track_q <= ddws_pkg::TRACK_W'(400);
      fac_q   <= ddws_pkg::FAC_W'(12518);
      spd_q   <= ddws_pkg::LIM_W'(3000);
      linv_q  <= 1'b0;
      rinv_q  <= 1'b1;
    end else if (cfg_we_i) begin
      case (ddws_pkg::cfg_reg_e'(cfg_idx_i))
        ddws_pkg::CFG_TRACK: track_q <= cfg_data_i[ddws_pkg::TRACK_W-1:0];
        ddws_pkg::CFG_FAC:   fac_q   <= cfg_data_i[ddws_pkg::FAC_W-1:0];
        ddws_pkg::CFG_LIMIT: spd_q   <= cfg_data_i[ddws_pkg::LIM_W-1:0];
        ddws_pkg::CFG_LINV:  linv_q  <= cfg_data_i[0];
        ddws_pkg::CFG_RINV:  rinv_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (longint'(spd_q) > ddws_pkg::RPM_MAX) begin
      lim_eff = ddws_pkg::LIM_W'(ddws_pkg::RPM_MAX);
    end else begin
      lim_eff = spd_q;
    end
  end

  // Stage valids and per-stage advance
  logic [NS-1:0] vld_q;
  logic [NS-1:0] vld_in;
  logic [NS-1:0] adv;

  always_comb begin
    adv[NS-1] = !vld_q[NS-1] || wheel_o.ready;
    for (int k = NS - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  assign vld_in       = {vld_q[NS-2:0], cmd_i.valid};
  assign cmd_i.ready  = adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vld_in[k];
        end
      end
    end
  end

  // Stage 0: scaled forward speed and yaw term
  logic signed [ddws_pkg::SUM_W-1:0] v2000_q, yaw_q;

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      v2000_q <= ddws_pkg::SUM_W'(cmd_i.linear_mmps) * 29'sd2000;
      yaw_q   <= ddws_pkg::SUM_W'(cmd_i.angular_mradps)
               * ddws_pkg::SUM_W'($signed({1'b0, track_q}));
    end
  end

  // Stage 1: rim speed numerators, lane 0 left, lane 1 right
  logic signed [ddws_pkg::SUM_W-1:0] sum_q [2];

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      sum_q[0] <= v2000_q - yaw_q;
      sum_q[1] <= v2000_q + yaw_q;
    end
  end

  // Stage 2: exact product with the rpm factor
  logic signed [ddws_pkg::N_W-1:0]   n_q [2];
  logic signed [ddws_pkg::FAC_W:0]   fac_s;

  assign fac_s = $signed({1'b0, fac_q});

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      for (int k = 0; k < 2; k++) begin
        n_q[k] <= ddws_pkg::N_W'(sum_q[k]) * ddws_pkg::N_W'(fac_s);
      end
    end
  end

  // Stage 3: magnitude divided by 2^20
  logic [ddws_pkg::N_W-1:0]  n_abs [2];
  logic [ddws_pkg::B_W-1:0]  b_q   [2];
  logic [1:0]                sgn3_q, sgn4_q, sgn5_q;

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      n_abs[k] = n_q[k][ddws_pkg::N_W-1] ? ddws_pkg::N_W'(-n_q[k])
                                          : ddws_pkg::N_W'(n_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      for (int k = 0; k < 2; k++) begin
        b_q[k]    <= n_abs[k][ddws_pkg::B_LSB +: ddws_pkg::B_W];
        sgn3_q[k] <= n_q[k][ddws_pkg::N_W-1];
      end
    end
  end

  // Stage 4: partial products of the reciprocal of 125
  logic [ddws_pkg::PP_W-1:0] plo_q [2];
  logic [ddws_pkg::PP_W-1:0] phi_q [2];

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      for (int k = 0; k < 2; k++) begin
        plo_q[k] <= ddws_pkg::PP_W'(b_q[k]) * ddws_pkg::PP_W'(ddws_pkg::RECIP_LO);
        phi_q[k] <= ddws_pkg::PP_W'(b_q[k]) * ddws_pkg::PP_W'(ddws_pkg::RECIP_HI);
      end
      sgn4_q <= sgn3_q;
    end
  end

  // Stage 5: truncated wheel rpm magnitude
  logic [ddws_pkg::ACC_W-1:0] acc   [2];
  logic [ddws_pkg::QW-1:0]    mag_q [2];

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      acc[k] = ddws_pkg::ACC_W'(plo_q[k])
             + (ddws_pkg::ACC_W'(phi_q[k]) << ddws_pkg::RECIP_SPLIT);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[5]) begin
      for (int k = 0; k < 2; k++) begin
        mag_q[k] <= acc[k][ddws_pkg::RECIP_SHIFT +: ddws_pkg::QW];
      end
      sgn5_q <= sgn4_q;
    end
  end

  // Stage 6: limit decision and divider setup; stages 7..21 one quotient bit each
  ddws_pkg::div_t div_q [DS+1];
  ddws_pkg::div_t prep;
  logic [ddws_pkg::QW-1:0] mmax;
  logic                    over, zero_lim;

  always_comb begin
    mmax     = (mag_q[1] > mag_q[0]) ? mag_q[1] : mag_q[0];
    over     = mmax > ddws_pkg::QW'(lim_eff);
    zero_lim = (lim_eff == '0);
    prep.scale   = over && !zero_lim;
    prep.limited = over || zero_lim;
    prep.sign    = sgn5_q;
    prep.m       = mmax;
    for (int k = 0; k < 2; k++) begin
      prep.rem[k] = ddws_pkg::PW'(mag_q[k]) * ddws_pkg::PW'(lim_eff);
      prep.quo[k] = (over || zero_lim) ? '0 : mag_q[k][ddws_pkg::LIM_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[SD]) begin
      div_q[0] <= prep;
    end
  end

  for (genvar j = 1; j <= DS; j++) begin : g_div
    localparam int Bit = DS - j;
    ddws_pkg::div_t         nxt;
    logic [ddws_pkg::PW-1:0] trial;

    always_comb begin
      nxt   = div_q[j-1];
      trial = ddws_pkg::PW'(div_q[j-1].m) << Bit;
      for (int k = 0; k < 2; k++) begin
        if (div_q[j-1].scale && (div_q[j-1].rem[k] >= trial)) begin
          nxt.rem[k]      = div_q[j-1].rem[k] - trial;
          nxt.quo[k][Bit] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[SD+j]) begin
        div_q[j] <= nxt;
      end
    end
  end

  // Output stage: polarity
  logic signed [ddws_pkg::LIM_W:0]     sv [2];
  logic [1:0]                          neg;
  logic signed [ddws_pkg::RPM_WIDTH-1:0] left_q, right_q;
  logic                                limited_q;

  always_comb begin
    neg = div_q[DS].sign ^ {rinv_q, linv_q};
    for (int k = 0; k < 2; k++) begin
      sv[k] = neg[k] ? -$signed({1'b0, div_q[DS].quo[k]})
                     : $signed({1'b0, div_q[DS].quo[k]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[NS-1]) begin
      left_q    <= ddws_pkg::RPM_WIDTH'(sv[0]);
      right_q   <= ddws_pkg::RPM_WIDTH'(sv[1]);
      limited_q <= div_q[DS].limited;
    end
  end

  assign wheel_o.valid       = vld_q[NS-1];
  assign wheel_o.left_speed  = left_q;
  assign wheel_o.right_speed = right_q;
  assign wheel_o.was_limited = limited_q;

  a_zero_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wheel_o.valid && (spd_q == '0) |->
      wheel_o.was_limited && (wheel_o.left_speed == '0) && (wheel_o.right_speed == '0))
    else $error("zero limit did not force zero output");

  a_scaled_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NS-2] && div_q[DS].scale |->
      (div_q[DS].quo[0] <= lim_eff) && (div_q[DS].quo[1] <= lim_eff))
    else $error("scaled wheel speed exceeds limit");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.ready |-> (&vld_q) && !wheel_o.ready)
    else $error("command side stalled with room in the pipeline");

  a_unscaled_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[SD] && !div_q[0].limited |-> div_q[0].m <= ddws_pkg::QW'(lim_eff))
    else $error("unlimited item above limit");

endmodule

`default_nettype wire

// File: tb/diff_drive_wheel_speed_tb.sv
// Self-checking testbench for diff_drive_wheel_speed: random chassis commands and
// register settings, wheel rpm predicted per transfer and compared in order.
// Depends on ddws_pkg, the channel interfaces in ddws_if.sv and the block itself.
`default_nettype none

module diff_drive_wheel_speed_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ddws_pkg::*;

  localparam int     NUM_PHASES     = 9;
  localparam int     RAND_PER_PHASE = 215;
  localparam int     RX_HOLD_CYCLES = 400;
  localparam int     SETTLE_CYCLES  = 30;
  localparam int     WATCHDOG_LIMIT = 4000;
  localparam longint RIM_DIVISOR    = 64'sd2000 * 64'sd65536;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd6;

  typedef struct packed {
    logic signed [IN_W-1:0] lin;
    logic signed [IN_W-1:0] ang;
  } chassis_cmd_t;

  typedef struct packed {
    logic signed [RPM_WIDTH-1:0] left;
    logic signed [RPM_WIDTH-1:0] right;
    logic                        limited;
  } wheel_speeds_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;

  ddws_cmd_if   cmd_if ();
  ddws_wheel_if wheel_if ();

  diff_drive_wheel_speed u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .cmd_i      (cmd_if),
    .wheel_o    (wheel_if)
  );

  logic [TRACK_W-1:0] track_mm;
  logic [FAC_W-1:0]   rpm_fac_q16;
  logic [LIM_W-1:0]   limit_rpm;
  logic               left_inv;
  logic               right_inv;

  chassis_cmd_t  cmd_queue[$];
  wheel_speeds_t wheel_q[$];
  int            errors;
  int            idle_cycles;
  int            tx_wait;
  int            rx_wait;
  int            hold_req;
  int            hold_ack;
  logic          tx_gap_en;
  logic          rx_stall_en;
  logic          cmd_fire_q;

  always #4 clk_i = ~clk_i;

  function automatic wheel_speeds_t predict_wheels(logic signed [IN_W-1:0] lin,
                                                   logic signed [IN_W-1:0] ang);
    longint        yaw;
    longint        left;
    longint        right;
    longint        peak;
    longint        cap;
    wheel_speeds_t res;
    yaw   = longint'(ang) * longint'(track_mm);
    left  = ((64'sd2000 * longint'(lin) - yaw) * longint'(rpm_fac_q16)) / RIM_DIVISOR;
    right = ((64'sd2000 * longint'(lin) + yaw) * longint'(rpm_fac_q16)) / RIM_DIVISOR;
    cap   = longint'(limit_rpm);
    if (cap > RPM_MAX) begin
      cap = RPM_MAX;
    end
    res.limited = 1'b0;
    if (cap == 0) begin
      left        = 0;
      right       = 0;
      res.limited = 1'b1;
    end else begin
      peak = (left < 0) ? -left : left;
      if (((right < 0) ? -right : right) > peak) begin
        peak = (right < 0) ? -right : right;
      end
      if (peak > cap) begin
        left        = (left * cap) / peak;
        right       = (right * cap) / peak;
        res.limited = 1'b1;
      end
    end
    if (left_inv) begin
      left = -left;
    end
    if (right_inv) begin
      right = -right;
    end
    res.left  = left[RPM_WIDTH-1:0];
    res.right = right[RPM_WIDTH-1:0];
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [IN_W-1:0] pick_speed();
    logic [IN_W-1:0] raw;
    raw = IN_W'($urandom());
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: return 16'sh7fff;
          1: return 16'sh8000;
          2: return 16'sh0000;
          3: return 16'sh0001;
          default: return 16'shffff;
        endcase
      end
      1, 2, 3: return $signed(IN_W'($urandom_range(0, 400))) - 16'sd200;
      default: return $signed(raw);
    endcase
  endfunction

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    case (idx)
      CFG_TRACK: track_mm    = data[TRACK_W-1:0];
      CFG_FAC:   rpm_fac_q16 = data[FAC_W-1:0];
      CFG_LIMIT: limit_rpm   = data[LIM_W-1:0];
      CFG_LINV:  left_inv    = data[0];
      CFG_RINV:  right_inv   = data[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // junk above each register's width checks the masking
  function automatic logic [CFG_W-1:0] with_junk(logic [CFG_W-1:0] val, int width);
    logic [CFG_W-1:0] junk;
    junk = CFG_W'($urandom());
    return (junk << width) | val;
  endfunction

  task automatic wait_results();
    do begin
      @(posedge clk_i);
      #1;
    end while (cmd_queue.size() != 0 || (cmd_if.valid && !cmd_fire_q) || wheel_q.size() != 0);
  endtask

  task automatic setup_phase(input int p);
    logic [CFG_W-1:0] fac;
    logic [CFG_W-1:0] lim;
    case (p)
      0: ;
      1: begin
        cfg_write(CFG_LIMIT, 24'h0);
        cfg_write(CFG_SPARE, 24'hffffff);
      end
      2: begin
        cfg_write(CFG_TRACK, 24'h0);
        cfg_write(CFG_FAC, 24'hffffff);
        cfg_write(CFG_LIMIT, 24'hffffff);
        cfg_write(CFG_LINV, 24'hffffff);
        cfg_write(CFG_RINV, 24'h1);
      end
      3: begin
        cfg_write(CFG_FAC, 24'h0);
        cfg_write(CFG_TRACK, 24'hfff);
        cfg_write(CFG_LIMIT, 24'h1);
        cfg_write(CFG_LINV, 24'h2);
        cfg_write(CFG_RINV, 24'h0);
      end
      4: begin
        cfg_write(CFG_TRACK, 24'h1);
        cfg_write(CFG_FAC, 24'h010000);
        cfg_write(CFG_LIMIT, 24'h7fff);
        cfg_write(CFG_LINV, 24'h1);
      end
      default: begin
        case ($urandom_range(0, 3))
          0: fac = CFG_W'($urandom_range(0, 65535));
          1: fac = CFG_W'($urandom_range(0, 1 << 20));
          2: fac = CFG_W'($urandom());
          default: fac = 24'd12518;
        endcase
        case ($urandom_range(0, 3))
          0: lim = CFG_W'($urandom_range(1, 100));
          1: lim = CFG_W'($urandom_range(0, 32767));
          2: lim = 24'h7fff;
          default: lim = CFG_W'($urandom_range(1000, 5000));
        endcase
        if ($urandom_range(0, 3) == 0) begin
          cfg_write(CFG_TRACK, with_junk(($urandom_range(0, 1) != 0) ? 24'hfff : 24'h0,
                                         TRACK_W));
        end else begin
          cfg_write(CFG_TRACK, with_junk(CFG_W'($urandom_range(1, 4095)), TRACK_W));
        end
        cfg_write(CFG_FAC, fac);
        cfg_write(CFG_LIMIT, with_junk(lim, LIM_W));
        cfg_write(CFG_LINV, with_junk(CFG_W'($urandom_range(0, 1)), 1));
        cfg_write(CFG_RINV, with_junk(CFG_W'($urandom_range(0, 1)), 1));
      end
    endcase
  endtask

  // sender: hold the command until it transfers, then advance
  always @(negedge clk_i) begin : drive_cmd
    chassis_cmd_t nxt;
    if (rst_ni && (!cmd_if.valid || cmd_fire_q)) begin
      if (tx_wait != 0) begin
        tx_wait      <= tx_wait - 1;
        cmd_if.valid <= 1'b0;
      end else if (cmd_queue.size() != 0) begin
        nxt                   = cmd_queue.pop_front();
        cmd_if.valid          <= 1'b1;
        cmd_if.linear_mmps    <= nxt.lin;
        cmd_if.angular_mradps <= nxt.ang;
        tx_wait               <= tx_gap_en ? pick_gap() : 0;
      end else begin
        cmd_if.valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_ack != hold_req) begin
        hold_ack       <= hold_req;
        rx_wait        <= RX_HOLD_CYCLES;
        wheel_if.ready <= 1'b0;
      end else if (rx_wait != 0) begin
        rx_wait        <= rx_wait - 1;
        wheel_if.ready <= 1'b0;
      end else begin
        wheel_if.ready <= 1'b1;
        rx_wait        <= rx_stall_en ? pick_gap() : 0;
      end
    end
  end

  always @(posedge clk_i) begin : check_wheels
    wheel_speeds_t want;
    if (!rst_ni) begin
      cmd_fire_q <= 1'b0;
    end else begin
      cmd_fire_q <= cmd_if.valid && cmd_if.ready;
      if (wheel_if.valid && wheel_if.ready) begin
        if (wheel_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected wheel transfer left %0d right %0d limited %0b", $time,
                   wheel_if.left_speed, wheel_if.right_speed, wheel_if.was_limited);
        end else begin
          want = wheel_q.pop_front();
          if (wheel_if.left_speed !== want.left) begin
            errors++;
            $display("%0t: left_speed expected %0d got %0d", $time, want.left,
                     wheel_if.left_speed);
          end
          if (wheel_if.right_speed !== want.right) begin
            errors++;
            $display("%0t: right_speed expected %0d got %0d", $time, want.right,
                     wheel_if.right_speed);
          end
          if (wheel_if.was_limited !== want.limited) begin
            errors++;
            $display("%0t: was_limited expected %0b got %0b", $time, want.limited,
                     wheel_if.was_limited);
          end
        end
      end
      if (cmd_if.valid && cmd_if.ready) begin
        wheel_q.push_back(predict_wheels(cmd_if.linear_mmps, cmd_if.angular_mradps));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((cmd_if.valid && cmd_if.ready) || (wheel_if.valid && wheel_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    chassis_cmd_t edge_cmds[12];
    clk_i                 = 1'b0;
    rst_ni                = 1'b0;
    cfg_we                = 1'b0;
    cfg_idx               = CFG_TRACK;
    cfg_data              = '0;
    cmd_if.valid          = 1'b0;
    cmd_if.linear_mmps    = '0;
    cmd_if.angular_mradps = '0;
    wheel_if.ready        = 1'b0;
    errors                = 0;
    idle_cycles           = 0;
    tx_wait               = 0;
    rx_wait               = 0;
    hold_req              = 0;
    hold_ack              = 0;
    tx_gap_en             = 1'b0;
    rx_stall_en           = 1'b0;
    cmd_fire_q            = 1'b0;
    track_mm              = 12'd400;
    rpm_fac_q16           = 24'd12518;
    limit_rpm             = 15'd3000;
    left_inv              = 1'b0;
    right_inv             = 1'b1;

    edge_cmds = '{'{16'sd0, 16'sd0}, '{16'sh7fff, 16'sd0}, '{16'sh8000, 16'sd0},
                  '{16'sd0, 16'sh7fff}, '{16'sd0, 16'sh8000}, '{16'sh7fff, 16'sh7fff},
                  '{16'sh8000, 16'sh8000}, '{16'sh7fff, 16'sh8000},
                  '{16'sh8000, 16'sh7fff}, '{16'sd100, 16'sd0}, '{-16'sd100, 16'sd500},
                  '{16'sd1, -16'sd1}};

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (edge_cmds[i]) begin
      cmd_queue.push_back(edge_cmds[i]);
    end
    wait_results();

    for (int p = 0; p < NUM_PHASES; p++) begin
      setup_phase(p);
      tx_gap_en   = (p % 3) != 0;
      rx_stall_en = (p % 4) != 1;
      if (p == 3 || p == 7) begin
        hold_req++;
      end
      for (int i = 0; i < RAND_PER_PHASE; i++) begin
        if (p == 5 && i == RAND_PER_PHASE / 2) begin
          wait_results();
        end
        cmd_queue.push_back('{pick_speed(), pick_speed()});
      end
      wait_results();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (errors == 0 && wheel_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
